FILE: sv/nps_pkg.sv
// shared types and constants for the priority scheduler
`default_nettype none
package nps_pkg;
	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int PRI_W  = 14;
	localparam int TIME_W = 21;
	localparam int TOT_W  = 25;
	localparam int AVG_W  = 27;
	localparam int NUM_W  = 5;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN,
		ST_IDLE_SCAN,
		ST_RUN,
		ST_REP_RD,
		ST_REP_OUT,
		ST_DIV,
		ST_SUM_OUT
	} state_t;

	typedef struct packed {
		logic [ARR_W-1:0] arrival;
		logic [BUR_W-1:0] burst;
		logic [PRI_W-1:0] prio;
	} job_t;
endpackage
`default_nettype wire

FILE: sv/nps_job_if.sv
// job input channel
`default_nettype none
interface nps_job_if;
	import nps_pkg::*;
	logic                valid;
	logic                ready;
	logic [ARR_W-1:0]    arrival_time;
	logic [BUR_W-1:0]    burst_length;
	logic [PRI_W-1:0]    job_priority;
	logic                last_job;
	modport source (output valid, arrival_time, burst_length, job_priority, last_job,
		input ready);
	modport sink (input valid, arrival_time, burst_length, job_priority, last_job,
		output ready);
endinterface
`default_nettype wire

FILE: sv/nps_rec_if.sv
// record output channel
`default_nettype none
interface nps_rec_if;
	import nps_pkg::*;
	logic               valid;
	logic               ready;
	logic               record_kind;
	logic [NUM_W-1:0]   job_number;
	logic [TIME_W-1:0]  completion_time;
	logic [TIME_W-1:0]  turnaround_time;
	logic [TIME_W-1:0]  waiting_time;
	logic [TOT_W-1:0]   total_turnaround;
	logic [TOT_W-1:0]   total_waiting;
	logic [AVG_W-1:0]   avg_turnaround_x100;
	logic [AVG_W-1:0]   avg_waiting_x100;
	logic               jobs_dropped;
	logic               last_record;
	modport source (output valid, record_kind, job_number, completion_time,
		turnaround_time, waiting_time, total_turnaround, total_waiting,
		avg_turnaround_x100, avg_waiting_x100, jobs_dropped, last_record, input ready);
	modport sink (input valid, record_kind, job_number, completion_time,
		turnaround_time, waiting_time, total_turnaround, total_waiting,
		avg_turnaround_x100, avg_waiting_x100, jobs_dropped, last_record, output ready);
endinterface
`default_nettype wire

FILE: sv/nps_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module nps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/nps_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module nps_div
	import nps_pkg::*;
#(
	parameter int NW = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [AVG_W+3:0]  dividend,
	input  wire logic [NW-1:0]     divisor,
	output logic                   busy,
	output logic [AVG_W-1:0]       quotient
);
	localparam int DW = AVG_W + 4;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [NW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   trial;

	assign trial = {rem_q[NW-1:0], num_q[DW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(DW);
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				num_q <= {num_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quotient = num_q[AVG_W-1:0];
endmodule
`default_nettype wire

FILE: sv/nonpreemptive_priority_scheduler_top.sv
// non-preemptive priority scheduler top level
// loads are accepted while in the load state; the last load starts scheduling
// each scheduled job costs one scan of the job ram plus one run state, and an idle scan
// and a fresh scan are added when the clock must jump to the next arrival
// reports read and then output each job's record, then two divisions give the averages
// asynchronous reset clears counts, finished marks, clock and flag
`default_nettype none
module nonpreemptive_priority_scheduler_top
	import nps_pkg::*;
#(
	parameter int MAX_JOBS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nps_job_if.sink   job,
	nps_rec_if.source rec
);
	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int JW = ARR_W + BUR_W + PRI_W;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     done_q;
	logic [TIME_W-1:0] clock_q;
	logic              ovf_q;
	logic [MAX_JOBS-1:0] fin_q;
	logic              rd_v_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic              found_q;
	logic [AW-1:0]     pick_q;
	logic [PRI_W-1:0]  best_pri_q;
	logic [BUR_W-1:0]  best_bur_q;
	logic [ARR_W-1:0]  best_arr_q;
	logic [TOT_W-1:0]  tot_tat_q, tot_wt_q;
	logic [AVG_W-1:0]  avg_tat_q;
	logic              div_sel_q;
	logic              div_act_q;

	logic              job_we, cmp_we;
	logic [AW-1:0]     job_raddr, job_waddr;
	logic [JW-1:0]     job_rdata;
	logic [TIME_W-1:0] cmp_rdata;
	job_t              rj;

	logic              div_start, div_busy;
	logic [AVG_W+3:0]  div_num;
	logic [AVG_W-1:0]  div_quo;

	logic [TIME_W-1:0] tat, wt, new_clock;
	logic              scan_end, rd_ok;

	assign rj = job_t'(job_rdata);
	assign job_we = job.valid && job.ready && (count_q < CW'(MAX_JOBS));
	assign job_waddr = count_q[AW-1:0];
	assign job_raddr = (state_q == ST_REP_OUT) ? AW'(idx_q - 1'b1) : idx_q[AW-1:0];
	assign rd_ok = idx_q < count_q;
	assign scan_end = (idx_q >= count_q) && !rd_v_s1;
	assign new_clock = clock_q + TIME_W'(best_bur_q);
	assign cmp_we = (state_q == ST_RUN);

	nps_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job_ram (
		.clk(clk), .we(job_we), .waddr(job_waddr),
		.wdata({job.arrival_time, job.burst_length, job.job_priority}),
		.raddr(job_raddr), .rdata(job_rdata)
	);

	nps_ram #(.WIDTH(TIME_W), .DEPTH(MAX_JOBS)) u_cmp_ram (
		.clk(clk), .we(cmp_we), .waddr(pick_q), .wdata(new_clock),
		.raddr(job_raddr), .rdata(cmp_rdata)
	);

	assign div_num = div_sel_q ? ((AVG_W+4)'(tot_wt_q) * (AVG_W+4)'(100))
		+ (AVG_W+4)'(count_q >> 1)
		: ((AVG_W+4)'(tot_tat_q) * (AVG_W+4)'(100)) + (AVG_W+4)'(count_q >> 1);
	assign div_start = (state_q == ST_DIV) && !div_busy && !div_act_q;

	nps_div #(.NW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(count_q), .busy(div_busy), .quotient(div_quo)
	);

	assign tat = cmp_rdata - TIME_W'(rj.arrival);
	assign wt  = tat - TIME_W'(rj.burst);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (job.valid && job.last_job) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = found_q ? ST_RUN : ST_IDLE_SCAN;
				end
			end
			ST_IDLE_SCAN: begin
				if (scan_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_RUN: begin
				state_d = (done_q + 1'b1 == count_q) ? ST_REP_RD : ST_SCAN;
			end
			ST_REP_RD: state_d = ST_REP_OUT;
			ST_REP_OUT: begin
				if (rec.ready) begin
					state_d = (idx_q < count_q) ? ST_REP_RD : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sel_q && div_act_q && !div_busy) begin
					state_d = ST_SUM_OUT;
				end
			end
			ST_SUM_OUT: begin
				if (rec.ready) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		job.ready = (state_q == ST_LOAD);
		rec.valid = (state_q == ST_REP_OUT) || (state_q == ST_SUM_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= ((state_q == ST_SCAN) || (state_q == ST_IDLE_SCAN)) && rd_ok;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			idx_q     <= '0;
			done_q    <= '0;
			clock_q   <= '0;
			ovf_q     <= 1'b0;
			fin_q     <= '0;
			found_q   <= 1'b0;
			div_sel_q <= 1'b0;
			div_act_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					done_q  <= '0;
					if (job.valid) begin
						if (count_q < CW'(MAX_JOBS)) begin
							count_q <= count_q + 1'b1;
							fin_q[count_q[AW-1:0]] <= 1'b0;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SCAN, ST_IDLE_SCAN: begin
					if (rd_ok) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_v_s1 && !fin_q[rd_idx_s1]) begin
						if (state_q == ST_SCAN) begin
							if (rj.arrival <= clock_q[ARR_W-1:0] && clock_q[TIME_W-1:ARR_W] == '0
								|| clock_q[TIME_W-1:ARR_W] != '0) begin
								if (!found_q || rj.prio < best_pri_q) begin
									found_q    <= 1'b1;
									best_pri_q <= rj.prio;
									best_bur_q <= rj.burst;
									pick_q     <= rd_idx_s1;
								end
							end
						end else if (!found_q || rj.arrival < best_arr_q) begin
							found_q    <= 1'b1;
							best_arr_q <= rj.arrival;
						end
					end
					if (scan_end) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						if (state_q == ST_IDLE_SCAN) begin
							clock_q <= TIME_W'(best_arr_q);
						end
					end
				end
				ST_RUN: begin
					clock_q       <= new_clock;
					fin_q[pick_q] <= 1'b1;
					done_q        <= done_q + 1'b1;
					idx_q         <= '0;
					tot_tat_q     <= '0;
					tot_wt_q      <= '0;
				end
				ST_REP_RD: begin
					idx_q <= idx_q + 1'b1;
				end
				ST_REP_OUT: begin
					if (rec.ready) begin
						tot_tat_q <= tot_tat_q + TOT_W'(tat);
						tot_wt_q  <= tot_wt_q + TOT_W'(wt);
						div_sel_q <= 1'b0;
						div_act_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_start) begin
						div_act_q <= 1'b1;
					end else if (div_act_q && !div_busy) begin
						div_act_q <= 1'b0;
						if (!div_sel_q) begin
							div_sel_q <= 1'b1;
							avg_tat_q <= div_quo;
						end
					end
				end
				ST_SUM_OUT: begin
					if (rec.ready) begin
						count_q   <= '0;
						clock_q   <= '0;
						ovf_q     <= 1'b0;
						fin_q     <= '0;
						div_sel_q <= 1'b0;
						tot_tat_q <= '0;
						tot_wt_q  <= '0;
						avg_tat_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		rec.record_kind         = (state_q == ST_SUM_OUT);
		rec.last_record         = (state_q == ST_SUM_OUT);
		rec.job_number          = '0;
		rec.completion_time     = '0;
		rec.turnaround_time     = '0;
		rec.waiting_time        = '0;
		rec.total_turnaround    = '0;
		rec.total_waiting       = '0;
		rec.avg_turnaround_x100 = '0;
		rec.avg_waiting_x100    = '0;
		rec.jobs_dropped        = 1'b0;
		if (state_q == ST_REP_OUT) begin
			rec.job_number      = NUM_W'(idx_q);
			rec.completion_time = cmp_rdata;
			rec.turnaround_time = tat;
			rec.waiting_time    = wt;
		end else if (state_q == ST_SUM_OUT) begin
			rec.total_turnaround    = tot_tat_q;
			rec.total_waiting       = tot_wt_q;
			rec.avg_turnaround_x100 = (count_q == '0) ? '0 : avg_tat_q;
			rec.avg_waiting_x100    = (count_q == '0) ? '0 : div_quo;
			rec.jobs_dropped        = ovf_q;
		end
	end

	a_pick_unfinished: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !fin_q[pick_q])
		else $error("picked job already finished");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_JOBS))
		else $error("job count overflow");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !job.ready)
		else $error("load accepted while busy");
	a_sum_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM_OUT && rec.ready) |=> (count_q == '0 && fin_q == '0))
		else $error("batch state not cleared");
endmodule
`default_nettype wire

FILE: test/tb_nonpreemptive_priority_scheduler_top.sv
// self-checking testbench for the non-preemptive priority scheduler
`default_nettype none
module tb_nonpreemptive_priority_scheduler_top;
	import nps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int DIR_ROWS = 8;

	typedef struct {
		logic               kind;
		logic [NUM_W-1:0]   num;
		logic [TIME_W-1:0]  comp;
		logic [TIME_W-1:0]  tat;
		logic [TIME_W-1:0]  wt;
		logic [TOT_W-1:0]   tot_tat;
		logic [TOT_W-1:0]   tot_wt;
		logic [AVG_W-1:0]   avg_tat;
		logic [AVG_W-1:0]   avg_wt;
		logic               dropped;
		logic               last;
	} record_t;

	typedef struct {
		logic [ARR_W-1:0] arr;
		logic [BUR_W-1:0] bur;
		logic [PRI_W-1:0] pri;
		logic             last;
		logic             has_sum;
		logic [TOT_W-1:0] sum_tat;
		logic [TOT_W-1:0] sum_wt;
	} job_row_t;

	logic clk;
	logic arst_n;
	nps_job_if job ();
	nps_rec_if rec ();

	nonpreemptive_priority_scheduler_top #(.MAX_JOBS(CAP)) u_top (
		.clk(clk), .arst_n(arst_n), .job(job.sink), .rec(rec.source)
	);

	logic [ARR_W-1:0] arr_q [CAP];
	logic [BUR_W-1:0] bur_q [CAP];
	logic [PRI_W-1:0] pri_q [CAP];
	int unsigned      jobs_held;
	logic             overflowed;
	record_t          expected_records [$];
	int               errors = 0;
	int               records_seen = 0;
	int               batches_seen = 0;
	int               jobs_sent = 0;
	int               idle_cycles = 0;
	int               send_gap_pct = 0;
	int               recv_gap_pct = 0;
	logic             timed_out = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// schedule the stored batch and queue its records
	task automatic schedule_batch();
		logic [63:0] sclk, tat, wt, tt, tw;
		logic [63:0] comp [CAP];
		logic done [CAP];
		int pick, finished;
		logic [63:0] nxt;
		record_t r;
		sclk = 0;
		tt = 0;
		tw = 0;
		finished = 0;
		for (int i = 0; i < CAP; i++) done[i] = 0;
		while (finished < jobs_held) begin
			pick = -1;
			for (int i = 0; i < jobs_held; i++)
				if (!done[i] && arr_q[i] <= sclk && (pick < 0 || pri_q[i] < pri_q[pick]))
					pick = i;
			if (pick < 0) begin
				nxt = '1;
				for (int i = 0; i < jobs_held; i++)
					if (!done[i] && arr_q[i] < nxt) nxt = arr_q[i];
				sclk = nxt;
			end else begin
				sclk += bur_q[pick];
				comp[pick] = sclk;
				done[pick] = 1;
				finished++;
			end
		end
		for (int i = 0; i < jobs_held; i++) begin
			tat = comp[i] - arr_q[i];
			wt = tat - bur_q[i];
			r = '{default: 0};
			r.num = NUM_W'(i + 1);
			r.comp = TIME_W'(comp[i]);
			r.tat = TIME_W'(tat);
			r.wt = TIME_W'(wt);
			tt += tat;
			tw += wt;
			expected_records.push_back(r);
		end
		r = '{default: 0};
		r.kind = 1;
		r.last = 1;
		r.tot_tat = TOT_W'(tt);
		r.tot_wt = TOT_W'(tw);
		if (jobs_held > 0) begin
			r.avg_tat = AVG_W'((tt * 100 + jobs_held / 2) / jobs_held);
			r.avg_wt = AVG_W'((tw * 100 + jobs_held / 2) / jobs_held);
		end
		r.dropped = overflowed;
		expected_records.push_back(r);
		jobs_held = 0;
		overflowed = 0;
	endtask

	function automatic void store_job(job_row_t j);
		if (jobs_held < CAP) begin
			arr_q[jobs_held] = j.arr;
			bur_q[jobs_held] = j.bur;
			pri_q[jobs_held] = j.pri;
			jobs_held++;
		end else
			overflowed = 1;
	endfunction

	task automatic send_job(job_row_t j);
		while ($urandom_range(99) < send_gap_pct) begin
			job.valid <= 0;
			@(negedge clk);
		end
		job.valid <= 1;
		job.arrival_time <= j.arr;
		job.burst_length <= j.bur;
		job.job_priority <= j.pri;
		job.last_job <= j.last;
		@(posedge clk);
		while (!job.ready) @(posedge clk);
		store_job(j);
		if (j.last) begin
			schedule_batch();
			if (j.has_sum) begin
				if (expected_records[$].tot_tat !== j.sum_tat) begin
					$error("directed total_turnaround expected %0d got %0d",
						j.sum_tat, expected_records[$].tot_tat);
					errors++;
				end
				if (expected_records[$].tot_wt !== j.sum_wt) begin
					$error("directed total_waiting expected %0d got %0d",
						j.sum_wt, expected_records[$].tot_wt);
					errors++;
				end
			end
		end
		jobs_sent++;
		@(negedge clk);
	endtask

	task automatic random_batch();
		job_row_t j;
		int n, mode;
		mode = $urandom_range(9);
		n = (mode == 0) ? $urandom_range(CAP + 3, CAP + 1) : $urandom_range(CAP, 1);
		for (int k = 0; k < n; k++) begin
			j = '{default: 0};
			case ($urandom_range(3))
				0: begin
					j.arr = ARR_W'($urandom);
					j.bur = BUR_W'($urandom);
				end
				default: begin
					j.arr = ARR_W'($urandom_range(60));
					j.bur = BUR_W'($urandom_range(20));
				end
			endcase
			j.pri = $urandom_range(3) == 0 ? PRI_W'($urandom) : PRI_W'($urandom_range(4));
			j.last = (k == n - 1);
			send_job(j);
		end
	endtask

	// directed rows: single job, extremes, ties, idle jump, high priorities
	job_row_t dir_rows [DIR_ROWS] = '{
		'{16'd0, 16'd0, 14'd0, 1'b1, 1'b1, 25'd0, 25'd0},
		'{16'hFFFF, 16'hFFFF, 14'h3FFF, 1'b1, 1'b1, 25'd65535, 25'd0},
		'{16'd0, 16'd5, 14'd3, 1'b0, 1'b0, 25'd0, 25'd0},
		'{16'd0, 16'd4, 14'd3, 1'b0, 1'b0, 25'd0, 25'd0},
		'{16'd100, 16'd2, 14'd0, 1'b1, 1'b1, 25'd16, 25'd5},
		'{16'd10, 16'd3, 14'h3FFF, 1'b0, 1'b0, 25'd0, 25'd0},
		'{16'd0, 16'd1, 14'd9999, 1'b0, 1'b0, 25'd0, 25'd0},
		'{16'd1, 16'd2, 14'd9998, 1'b1, 1'b0, 25'd0, 25'd0}
	};

	initial begin
		job_row_t j;
		arst_n = 0;
		job.valid = 0;
		job.arrival_time = 0;
		job.burst_length = 0;
		job.job_priority = 0;
		job.last_job = 0;
		jobs_held = 0;
		overflowed = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_gap_pct = 12;
		recv_gap_pct = 49;
		foreach (dir_rows[i]) send_job(dir_rows[i]);
		// overflow with last job on a dropped load
		for (int k = 0; k <= CAP; k++) begin
			j = '{default: 0};
			j.arr = ARR_W'(k);
			j.bur = 16'hFFFF;
			j.pri = PRI_W'(k[0]);
			j.last = (k == CAP);
			send_job(j);
		end
		while (jobs_sent < 150) random_batch();
		send_gap_pct = 49;
		recv_gap_pct = 12;
		while (jobs_sent < 280) random_batch();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		while (jobs_sent < 370) random_batch();
		job.valid <= 0;
		while (expected_records.size() > 0 && !timed_out) @(posedge clk);
		repeat (50) @(posedge clk);
		if (timed_out) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			$display("sent %0d jobs, checked %0d records over %0d batches",
				jobs_sent, records_seen, batches_seen);
			if (errors == 0 && expected_records.size() == 0)
				$display("TB_OK");
			else
				$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		rec.ready = 0;
		forever begin
			@(negedge clk);
			rec.ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s expected %0d got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		record_t e;
		if (arst_n && rec.valid && rec.ready) begin
			records_seen++;
			if (expected_records.size() == 0) begin
				$error("record beat with nothing expected");
				errors++;
			end else begin
				e = expected_records.pop_front();
				cmp("record_kind", 32'(e.kind), 32'(rec.record_kind));
				cmp("job_number", 32'(e.num), 32'(rec.job_number));
				cmp("completion_time", 32'(e.comp), 32'(rec.completion_time));
				cmp("turnaround_time", 32'(e.tat), 32'(rec.turnaround_time));
				cmp("waiting_time", 32'(e.wt), 32'(rec.waiting_time));
				cmp("total_turnaround", 32'(e.tot_tat), 32'(rec.total_turnaround));
				cmp("total_waiting", 32'(e.tot_wt), 32'(rec.total_waiting));
				cmp("avg_turnaround_x100", 32'(e.avg_tat), 32'(rec.avg_turnaround_x100));
				cmp("avg_waiting_x100", 32'(e.avg_wt), 32'(rec.avg_waiting_x100));
				cmp("jobs_dropped", 32'(e.dropped), 32'(rec.jobs_dropped));
				cmp("last_record", 32'(e.last), 32'(rec.last_record));
				if (e.last) batches_seen++;
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((job.valid && job.ready) || (rec.valid && rec.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT && !timed_out) begin
			timed_out <= 1;
			$display("TB_ERROR");
			$finish;
		end
	end
endmodule
`default_nettype wire
